// File: design/rtpg_pkg.sv
// ----------------------------------------------------------------------------
// rtpg_pkg
// Shared types, constants and note tables of the random tick pattern generator.
// ----------------------------------------------------------------------------
package rtpg_pkg;

   // Generator constants
   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_INC = 32'd2531011;
   // Multiplier of the accent test used by the psych and flat styles
   localparam logic [41:0] ACC_MUL = 42'h057619F1;

   // Widths of the fields
   localparam int unsigned SEED_W = 32;
   localparam int unsigned DRAW_W = 15;
   localparam int unsigned VEL_W  = 8;
   localparam int unsigned NOTE_W = 5;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned RSP_W  = 16;

   // Input transaction kinds
   localparam logic KIND_SEED = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Generator styles
   localparam logic [MODE_W-1:0] MODE_PSYCH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FLAT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GOA   = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW1,
      ST_DRAW2,
      ST_DRAW3,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_seed;
      logic draw1;
      logic draw2;
      logic draw3;
      logic load_out;
   } cmd_type;

   typedef logic signed [NOTE_W-1:0] note_type;

   function automatic note_type psych_note(input logic [2:0] idx);
      note_type n;
      case (idx)
         3'd2:    n = -5'sd2;
         3'd3:    n = 5'sd3;
         3'd4:    n = 5'sd15;
         3'd5:    n = 5'sd10;
         3'd7:    n = 5'sd12;
         default: n = 5'sd0;
      endcase
      return n;
   endfunction

   function automatic note_type flat_note(input logic [2:0] idx);
      note_type n;
      case (idx)
         3'd1:    n = -5'sd12;
         3'd3:    n = 5'sd13;
         3'd7:    n = 5'sd12;
         default: n = 5'sd0;
      endcase
      return n;
   endfunction

   function automatic note_type goa_plain_note(input logic [2:0] idx);
      note_type n;
      case (idx)
         3'd1:    n = -5'sd12;
         3'd3:    n = 5'sd1;
         3'd4:    n = 5'sd3;
         3'd5:    n = 5'sd7;
         3'd6:    n = 5'sd12;
         3'd7:    n = 5'sd13;
         default: n = 5'sd0;
      endcase
      return n;
   endfunction

   function automatic note_type goa_accent_note(input logic [2:0] idx);
      note_type n;
      case (idx)
         3'd1:    n = -5'sd12;
         3'd2:    n = -5'sd2;
         3'd4:    n = 5'sd3;
         3'd5:    n = -5'sd14;
         3'd6:    n = 5'sd1;
         default: n = 5'sd0;
      endcase
      return n;
   endfunction

endpackage

// File: design/rtpg_ctrl.sv
// ----------------------------------------------------------------------------
// rtpg_ctrl
// Sequencer of the generator: accepts transactions, steps the three draws
// of a tick and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module rtpg_ctrl
   import rtpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_kind,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DRAW1: begin
            cmd.draw1 = 1'b1;
            state_in  = ST_DRAW2;
         end
         ST_DRAW2: begin
            cmd.draw2 = 1'b1;
            state_in  = ST_DRAW3;
         end
         ST_DRAW3: begin
            cmd.draw3 = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // result goes out once the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               req_tready   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a new transaction starts in the idle state or beside the result load
      if (req_tvalid && req_tready) begin
         if (req_kind == KIND_TICK) begin
            state_in = ST_DRAW1;
         end else begin
            cmd.load_seed = 1'b1;
         end
      end
   end

   // Assertions
   a_no_ready_while_drawing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW1 || state_ff == ST_DRAW2 || state_ff == ST_DRAW3)
         |-> !req_tready)
      else $error("input ready while a tick is being drawn");

   a_tick_starts_draw: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_TICK) |=> state_ff == ST_DRAW1)
      else $error("accepted tick did not start the draw sequence");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result loaded over a pending result");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result valid raised outside the output state");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.draw1, cmd.draw2, cmd.draw3, cmd.load_out}))
      else $error("more than one datapath step in a cycle");

endmodule

// File: design/rtpg_datapath.sv
// ----------------------------------------------------------------------------
// rtpg_datapath
// Generator state, the draw multiplier, the accent test and the note tables,
// plus the result register.
// ----------------------------------------------------------------------------
module rtpg_datapath
   import rtpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [SEED_W-1:0] seed_value,
   input  logic [MODE_W-1:0] mode,
   output logic [VEL_W-1:0]  velocity,
   output logic              accent,
   output note_type          note
);

   logic [SEED_W-1:0] lcg_state_ff, lcg_state_in;
   logic [VEL_W-1:0]  vel_ff;
   logic [DRAW_W-1:0] d2_ff;
   logic [DRAW_W-1:0] d3_ff;
   logic              acc_ff, acc_in;
   logic [41:0]       acc_prod;
   logic [VEL_W-1:0]  out_vel_ff;
   logic              out_acc_ff;
   note_type          out_note_ff, note_in;
   logic              is_goa;

   assign is_goa = mode[1];

   // One generator step: multiply and add, wrapping at 32 bits
   assign lcg_state_in = lcg_state_ff * LCG_MUL + LCG_INC;

   // Accent test on the second draw
   assign acc_prod = {27'd0, d2_ff} * ACC_MUL;
   assign acc_in   = is_goa ? d2_ff[13] : (acc_prod[41] | acc_prod[31]);

   // Note lookup from the third draw
   always_comb begin
      if (is_goa) begin
         note_in = acc_ff ? goa_accent_note(d3_ff[2:0]) : goa_plain_note(d3_ff[2:0]);
      end else if (mode[0]) begin
         note_in = flat_note(d3_ff[14:12]);
      end else begin
         note_in = psych_note(d3_ff[14:12]);
      end
   end

   // Generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_state_ff <= '0;
      end else if (cmd.load_seed) begin
         lcg_state_ff <= seed_value;
      end else if (cmd.draw1 || cmd.draw2 || cmd.draw3) begin
         lcg_state_ff <= lcg_state_in;
      end
   end

   // Draw registers
   always_ff @(posedge clock) begin
      if (cmd.draw1) begin
         vel_ff <= lcg_state_in[30:23];
      end
      if (cmd.draw2) begin
         d2_ff <= lcg_state_in[30:16];
      end
      if (cmd.draw3) begin
         d3_ff  <= lcg_state_in[30:16];
         acc_ff <= acc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_vel_ff  <= vel_ff;
         out_acc_ff  <= acc_ff;
         out_note_ff <= note_in;
      end
   end

   assign velocity = out_vel_ff;
   assign accent   = out_acc_ff;
   assign note     = out_note_ff;

endmodule

// File: design/random_tick_pattern_generator.sv
// ----------------------------------------------------------------------------
// random_tick_pattern_generator
// Random tick generator driven by a 32-bit linear congruential generator.
//
// Usage:
//   req channel: tuser is the kind (0 seed, 1 tick), tdata the seed value.
//   A seed transaction loads the generator state and returns nothing.
//   A tick transaction makes three draws and returns one rsp transaction
//   with velocity, accent and note offset.
//   csr port: register 0 at address 0 holds the style (0 psych, 1 flat,
//   2 or 3 goa); write it only while the block is idle.
// Sequence:
//   A tick runs its three draws in turn through the shared generator
//   multiplier, then fills the output register; the next transaction can be
//   taken beside that load, but never while a tick is drawing.
//   A seed loads the generator state on acceptance and the block stays idle.
// Reset clears the generator state to zero, the style to psych and the
//   result valid flag. If the receiver stalls, the finished result waits in
//   the output register; the next tick still runs its draws and then holds
//   until the register is taken.
// ----------------------------------------------------------------------------
module random_tick_pattern_generator
   import rtpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] velocity, [8] accent, [13:9] note, [15:14] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type           cmd;
   logic [MODE_W-1:0] mode_ff;
   logic [VEL_W-1:0]  velocity;
   logic              accent;
   note_type          note;
   logic              csr_write;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PSYCH;
      end else if (csr_write && !csr_paddr[2]) begin
         mode_ff <= csr_pwdata[MODE_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {30'd0, mode_ff};

   rtpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rtpg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .seed_value (req_tdata),
      .mode       (mode_ff),
      .velocity   (velocity),
      .accent     (accent),
      .note       (note)
   );

   assign rsp_tdata = {2'b00, note, accent, velocity};

endmodule

// File: dv/random_tick_pattern_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_tick_pattern_generator_tb
// Self-checking bench for the random tick pattern generator. A short
// stimulus table covers reset state, seed extremes and every style. It is
// followed by random seed/tick traffic in several style phases. Tick results
// are compared field by field against an in-bench model of the LCG and note
// tables, or against fixed table values. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module random_tick_pattern_generator_tb;
   import rtpg_pkg::*;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          PHASE_ITEMS   = 125;
   localparam int          SETTLE_CYCLES = 8;
   localparam logic [2:0]  CSR_MODE_ADDR = 3'd0;
   // unused style code, decoded as goa
   localparam logic [1:0]  MODE_GOA_ALT  = 2'd3;

   localparam logic [31:0] GEN_MUL  = 32'd214013;
   localparam logic [31:0] GEN_INC  = 32'd2531011;
   localparam logic [63:0] PROBE_MUL = 64'h0000_0000_0576_19F1;

   // note tables, entry 0 in the lowest 5 bits
   localparam logic [39:0] PSYCH_NOTES      = {5'sd12, 5'sd0, 5'sd10, 5'sd15,
                                               5'sd3, -5'sd2, 5'sd0, 5'sd0};
   localparam logic [39:0] FLAT_NOTES       = {5'sd12, 5'sd0, 5'sd0, 5'sd0,
                                               5'sd13, 5'sd0, -5'sd12, 5'sd0};
   localparam logic [39:0] GOA_PLAIN_NOTES  = {5'sd13, 5'sd12, 5'sd7, 5'sd3,
                                               5'sd1, 5'sd0, -5'sd12, 5'sd0};
   localparam logic [39:0] GOA_ACCENT_NOTES = {5'sd0, 5'sd1, -5'sd14, 5'sd3,
                                               5'sd0, -5'sd2, -5'sd12, 5'sd0};

   typedef struct packed {
      logic [VEL_W-1:0] velocity;
      logic             accent;
      note_type         note;
   } tick_result_type;

   typedef struct packed {
      logic [MODE_W-1:0] style;
      logic              kind;
      logic [SEED_W-1:0] seed;
      logic              known;
      tick_result_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] seed_value
   logic        req_tuser = 1'b0;  // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;         // [7:0] velocity, [8] accent, [13:9] note, [15:14] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // model state and bookkeeping
   logic [31:0]       lcg_model;
   logic [MODE_W-1:0] style_model;
   tick_result_type   pending_ticks[$];
   stim_row_type      plan[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                src_idle_pct = 0;
   int                sink_stall_pct = 0;
   int                sink_stall_left = 0;
   bit                calm = 1'b0;

   random_tick_pattern_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // one generator step, returns state bits 16 to 30
   function automatic logic [DRAW_W-1:0] lcg_next();
      lcg_model = lcg_model * GEN_MUL + GEN_INC;
      return lcg_model[30:16];
   endfunction

   // three draws: velocity, accent, note
   function automatic tick_result_type roll_tick();
      logic [DRAW_W-1:0] d1, d2, d3;
      logic [63:0]       prod;
      logic [2:0]        idx;
      tick_result_type   r;
      d1 = lcg_next();
      d2 = lcg_next();
      d3 = lcg_next();
      r.velocity = d1[14:7];
      if (style_model[1]) begin
         r.accent = d2[13];
         idx = d3[2:0];
         r.note = r.accent ? GOA_ACCENT_NOTES[idx*5 +: 5] : GOA_PLAIN_NOTES[idx*5 +: 5];
      end else begin
         prod = {49'b0, d2} * PROBE_MUL;
         r.accent = prod[41] | prod[31];
         idx = d3[14:12];
         r.note = style_model[0] ? FLAT_NOTES[idx*5 +: 5] : PSYCH_NOTES[idx*5 +: 5];
      end
      return r;
   endfunction

   function automatic stim_row_type plan_row(logic [MODE_W-1:0] style, logic kind,
                                             logic [31:0] seed, logic known,
                                             logic [7:0] vel, logic acc, note_type note);
      stim_row_type r;
      r.style         = style;
      r.kind          = kind;
      r.seed          = seed;
      r.known         = known;
      r.want.velocity = vel;
      r.want.accent   = acc;
      r.want.note     = note;
      return r;
   endfunction

   // drive one transaction; returns at the accepting edge with tvalid high, or after a random idle with it low
   task automatic send_request(logic kind, logic [31:0] seed, logic known,
                               tick_result_type want);
      tick_result_type model_tick;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seed;
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_SEED) begin
         lcg_model = seed;
      end else begin
         model_tick = roll_tick();
         pending_ticks.push_back(known ? want : model_tick);
      end
      if (!calm && $urandom_range(1, 100) <= src_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tuser  <= 1'($urandom_range(0, 1));
         req_tdata  <= $urandom;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // style write with read-back, only once the block has gone quiet
   task automatic apply_style(logic [MODE_W-1:0] style);
      req_tvalid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_MODE_ADDR;
      csr_pwdata  <= {30'b0, style};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      style_model = style;
      // read back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {30'b0, style}) begin
         $error("mode readback: expected %0d, actual %0d", style, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result sink: random stall bursts
   always @(posedge clock) begin
      if (sink_stall_left != 0)
         sink_stall_left = sink_stall_left - 1;
      else if (!calm && $urandom_range(1, 100) <= sink_stall_pct)
         sink_stall_left = $urandom_range(1, 18);
      rsp_tready <= (sink_stall_left == 0);
   end

   // result checker
   always @(posedge clock) begin
      tick_result_type exp_tick;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ticks.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            exp_tick = pending_ticks.pop_front();
            if (rsp_tdata[7:0] !== exp_tick.velocity) begin
               $error("velocity: expected %0d, actual %0d", exp_tick.velocity, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tdata[8] !== exp_tick.accent) begin
               $error("accent: expected %0d, actual %0d", exp_tick.accent, rsp_tdata[8]);
               mismatch_count++;
            end
            if (rsp_tdata[13:9] !== exp_tick.note) begin
               $error("note: expected %0d, actual %0d", exp_tick.note,
                      $signed(rsp_tdata[13:9]));
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("random_tick_pattern_generator_tb failed");
         $finish;
      end
   end

   initial begin
      logic [MODE_W-1:0] style_now;
      logic [MODE_W-1:0] phase_styles[6];
      logic              kind;
      logic [31:0]       seed;
      lcg_model   = '0;
      style_model = MODE_PSYCH;
      style_now   = MODE_PSYCH;

      // directed table: reset state, seed extremes, every style
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'h0,        1, 8'd0, 1'b1, 5'sd10));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_SEED, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'h0,        1, 8'd0, 1'b1, 5'sd10));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_SEED, 32'hFFFFFFFF, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'hFFFFFFFF, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_SEED, 32'h80000000, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_SEED, 32'h7FFFFFFF, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_PSYCH,   KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_FLAT,    KIND_SEED, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_FLAT,    KIND_TICK, 32'h0,        1, 8'd0, 1'b1, 5'sd0));
      plan.push_back(plan_row(MODE_FLAT,    KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_FLAT,    KIND_SEED, 32'h0000FFFF, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_FLAT,    KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA,     KIND_SEED, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA,     KIND_TICK, 32'h0,        1, 8'd0, 1'b0, 5'sd12));
      plan.push_back(plan_row(MODE_GOA,     KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA,     KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA,     KIND_SEED, 32'hFFFF0000, 0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA,     KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA_ALT, KIND_SEED, 32'h0,        0, 8'd0, 1'b0, 5'sd0));
      plan.push_back(plan_row(MODE_GOA_ALT, KIND_TICK, 32'h0,        1, 8'd0, 1'b0, 5'sd12));
      plan.push_back(plan_row(MODE_GOA_ALT, KIND_TICK, 32'h0,        0, 8'd0, 1'b0, 5'sd0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, moderate idling on both sides
      src_idle_pct   = 25;
      sink_stall_pct = 20;
      foreach (plan[i]) begin
         if (plan[i].style != style_now) begin
            apply_style(plan[i].style);
            style_now = plan[i].style;
         end
         send_request(plan[i].kind, plan[i].seed, plan[i].known, plan[i].want);
      end

      // random phases; the last one runs without idling
      phase_styles = '{MODE_GOA, MODE_FLAT, MODE_PSYCH, MODE_GOA_ALT, MODE_GOA, MODE_FLAT};
      foreach (phase_styles[p]) begin
         apply_style(phase_styles[p]);
         calm = (p == 5);
         case ($urandom_range(0, 2))
            0: begin
               src_idle_pct   = 0;
               sink_stall_pct = 30;
            end
            1: begin
               src_idle_pct   = 30;
               sink_stall_pct = 0;
            end
            default: begin
               src_idle_pct   = $urandom_range(5, 40);
               sink_stall_pct = $urandom_range(5, 40);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = ($urandom_range(1, 100) <= 12) ? KIND_SEED : KIND_TICK;
            case ($urandom_range(0, 9))
               0:       seed = 32'h0;
               1:       seed = 32'hFFFFFFFF;
               default: seed = $urandom;
            endcase
            send_request(kind, seed, 1'b0, '0);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("random_tick_pattern_generator_tb passed");
      else
         $display("random_tick_pattern_generator_tb failed");
      $finish;
   end

endmodule
